>>> design/udp_flood_flow_blocker_defines.svh
// ----------------------------------------------------------------------------
// UDP flood flow blocker assertion macros
// Shared concurrent assertion forms used by ufb_engine.
// ----------------------------------------------------------------------------
`ifndef UDP_FLOOD_FLOW_BLOCKER_DEFINES_SVH
`define UDP_FLOOD_FLOW_BLOCKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UFB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ufb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UFB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ufb assertion failed");

`endif

>>> design/ufb_pkg.sv
// ----------------------------------------------------------------------------
// ufb_pkg
// Sizes, codes, state and record types of the UDP flood flow blocker.
// ----------------------------------------------------------------------------
package ufb_pkg;

   localparam int FLOW_ENTRIES  = 64;
   localparam int BLOCK_ENTRIES = 2048;
   localparam int ALLOW_ENTRIES = 512;

   localparam int FLOW_AW  = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int BLOCK_AW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
   localparam int ALLOW_AW = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;
   localparam int FLOW_CW  = $clog2(FLOW_ENTRIES + 1);
   localparam int BLOCK_CW = $clog2(BLOCK_ENTRIES + 1);
   localparam int ALLOW_CW = $clog2(ALLOW_ENTRIES + 1);
   localparam int IDX_W    = (BLOCK_CW > ALLOW_CW) ?
                             ((BLOCK_CW > FLOW_CW) ? BLOCK_CW : FLOW_CW) :
                             ((ALLOW_CW > FLOW_CW) ? ALLOW_CW : FLOW_CW);

   localparam int COUNT_W = 24;
   localparam int FLOW_DW = 32 + 16 + COUNT_W;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [2:0] CMD_PACKET  = 3'd0;
   localparam logic [2:0] CMD_WINDOW  = 3'd1;
   localparam logic [2:0] CMD_ALLOW   = 3'd2;
   localparam logic [2:0] CMD_DISALOW = 3'd3;
   localparam logic [2:0] CMD_UNBLOCK = 3'd4;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_BLOCKED = 2'd1;
   localparam logic [1:0] KIND_WINDOW  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   localparam logic [1:0] CSR_RATE  = 2'd0;
   localparam logic [1:0] CSR_Q8    = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   localparam logic [15:0] ETHER_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [15:0] DEF_RATE   = 16'd60;
   localparam logic [15:0] DEF_Q8     = 16'd384;
   localparam logic [15:0] Q8_FLOOR   = 16'd25;
   localparam logic [11:0] DEF_LIMIT  = 12'd2048;

   typedef enum logic [1:0] {LIST_FLOW, LIST_ALLOW, LIST_BLOCK} list_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_FLOW_UPD,
      ST_WIN_START, ST_WIN_RD, ST_WIN_CHK, ST_WIN_ALW, ST_WIN_BLK, ST_WIN_PUSH,
      ST_WIN_END, ST_ADD_A, ST_ADD_B, ST_DEL_A, ST_UNB_A, ST_RM_RD, ST_RM_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [31:0] blocked_address;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [15:0] rate;
      logic [15:0] q8;
      logic [11:0] limit;
   } cfg_type;

endpackage

>>> design/ufb_if.sv
// ----------------------------------------------------------------------------
// ufb channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [15:0] type_plain;
   logic [15:0] type_shifted;
   logic [7:0]  proto_plain;
   logic [7:0]  proto_shifted;
   logic [31:0] source_plain;
   logic [31:0] source_shifted;
   logic [15:0] port_plain;
   logic [15:0] port_shifted;
   logic [31:0] table_address;

   modport source (output valid, command, type_plain, type_shifted, proto_plain,
                   proto_shifted, source_plain, source_shifted, port_plain,
                   port_shifted, table_address, input ready);
   modport sink (input valid, command, type_plain, type_shifted, proto_plain,
                 proto_shifted, source_plain, source_shifted, port_plain,
                 port_shifted, table_address, output ready);
endinterface

interface ufb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  status;
   logic [31:0] blocked_address;
   logic        last;

   modport source (output valid, kind, status, blocked_address, last, input ready);
   modport sink (input valid, kind, status, blocked_address, last, output ready);
endinterface

>>> design/ufb_ram.sv
// ----------------------------------------------------------------------------
// ufb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ufb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                         wdata,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

>>> design/ufb_engine.sv
// ----------------------------------------------------------------------------
// ufb_engine
// Sequencer that walks the flow, allow and block lists with one compare unit.
// ----------------------------------------------------------------------------
`include "udp_flood_flow_blocker_defines.svh"

module ufb_engine import ufb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   ufb_req_if.sink              req,
   ufb_rsp_if.source            rsp,
   output logic                 flow_we,
   output logic [FLOW_AW-1:0]   flow_addr,
   output logic [FLOW_DW-1:0]   flow_wdata,
   input  logic [FLOW_DW-1:0]   flow_rdata,
   output logic                 allow_we,
   output logic [ALLOW_AW-1:0]  allow_addr,
   output logic [31:0]          allow_wdata,
   input  logic [31:0]          allow_rdata,
   output logic                 block_we,
   output logic [BLOCK_AW-1:0]  block_addr,
   output logic [31:0]          block_wdata,
   input  logic [31:0]          block_rdata
);
   state_type            state_ff, state_in, cont_ff, cont_in;
   list_type             sel_ff, sel_in;
   logic [IDX_W-1:0]     i_ff, i_in, idx_ff, idx_in, len;
   logic                 found_ff, found_in;
   logic [31:0]          key_ff, key_in;
   logic [15:0]          port_ff, port_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in, limit_ff, limit_in;
   logic [1:0]           status_ff, status_in;
   logic [FLOW_CW-1:0]   fi_ff, fi_in, flows_ff, flows_in;
   logic [BLOCK_CW-1:0]  blocks_ff, blocks_in;
   logic [ALLOW_CW-1:0]  allows_ff, allows_in;
   logic                 pend_v_ff, pend_v_in, out_v_ff, out_v_in;
   logic [31:0]          pend_addr_ff, pend_addr_in;
   result_type           out_ff, out_in;

   logic                 accept, plain_ok, shifted_ok, match, out_free;
   logic                 qualify, room;
   logic [31:0]          list_rdata;
   logic [15:0]          rate_eff, q_eff;
   logic [31:0]          product;

   assign accept     = req.valid && req.ready;
   assign plain_ok   = (req.type_plain == ETHER_IPV4) && (req.proto_plain == PROTO_UDP);
   assign shifted_ok = (req.type_plain != ETHER_IPV4) && (req.type_shifted == ETHER_IPV4)
                       && (req.proto_shifted == PROTO_UDP);
   assign out_free   = !out_v_ff || rsp.ready;
   assign rate_eff   = (cfg.rate == 16'd0) ? DEF_RATE : cfg.rate;
   assign q_eff      = (cfg.q8 > Q8_FLOOR) ? cfg.q8 : DEF_Q8;
   assign product    = 32'(rate_eff) * 32'(q_eff);
   assign room       = (32'(blocks_ff) < 32'(cfg.limit)) && (32'(blocks_ff) < BLOCK_ENTRIES);
   assign qualify    = (flow_rdata[COUNT_W-1:0] >= limit_ff) && room;

   // The one compare unit: the list under scan against the search key.
   always_comb begin
      case (sel_ff)
         LIST_FLOW: begin
            len        = IDX_W'(flows_ff);
            list_rdata = flow_rdata[FLOW_DW-1:FLOW_DW-32];
            match      = (flow_rdata[FLOW_DW-1:COUNT_W] == {key_ff, port_ff});
         end
         LIST_ALLOW: begin
            len        = IDX_W'(allows_ff);
            list_rdata = allow_rdata;
            match      = (allow_rdata == key_ff);
         end
         LIST_BLOCK: begin
            len        = IDX_W'(blocks_ff);
            list_rdata = block_rdata;
            match      = (block_rdata == key_ff);
         end
         default: begin
            len        = '0;
            list_rdata = '0;
            match      = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.command)
                  CMD_PACKET:  state_in = (plain_ok || shifted_ok) ? ST_SCAN_RD : ST_IDLE;
                  CMD_WINDOW:  state_in = ST_WIN_START;
                  CMD_ALLOW:   state_in = ST_SCAN_RD;
                  CMD_DISALOW: state_in = ST_SCAN_RD;
                  CMD_UNBLOCK: state_in = ST_SCAN_RD;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN_RD:   state_in = (i_ff == len) ? cont_ff : ST_SCAN_CMP;
         ST_SCAN_CMP:  state_in = match ? cont_ff : ST_SCAN_RD;
         ST_FLOW_UPD:  state_in = ST_IDLE;
         ST_WIN_START: state_in = ST_WIN_RD;
         ST_WIN_RD:    state_in = (fi_ff == flows_ff) ? ST_WIN_END : ST_WIN_CHK;
         ST_WIN_CHK:   state_in = qualify ? ST_SCAN_RD : ST_WIN_RD;
         ST_WIN_ALW:   state_in = found_ff ? ST_WIN_RD : ST_SCAN_RD;
         ST_WIN_BLK:   state_in = found_ff ? ST_WIN_RD : ST_WIN_PUSH;
         ST_WIN_PUSH:  state_in = (!pend_v_ff || out_free) ? ST_WIN_RD : ST_WIN_PUSH;
         ST_WIN_END:   state_in = out_free ? ST_IDLE : ST_WIN_END;
         ST_ADD_A: begin
            if (found_ff || (32'(allows_ff) >= ALLOW_ENTRIES)) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_ADD_B:     state_in = found_ff ? ST_RM_RD : ST_RESP;
         ST_DEL_A:     state_in = found_ff ? ST_RM_RD : ST_RESP;
         ST_UNB_A:     state_in = found_ff ? ST_RM_RD : ST_RESP;
         ST_RM_RD:     state_in = (i_ff == len) ? cont_ff : ST_RM_WR;
         ST_RM_WR:     state_in = ST_RM_RD;
         ST_RESP:      state_in = out_free ? ST_IDLE : ST_RESP;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cont_in      = cont_ff;
      sel_in       = sel_ff;
      i_in         = i_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      key_in       = key_ff;
      port_in      = port_ff;
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      status_in    = status_ff;
      fi_in        = fi_ff;
      flows_in     = flows_ff;
      blocks_in    = blocks_ff;
      allows_in    = allows_ff;
      pend_v_in    = pend_v_ff;
      pend_addr_in = pend_addr_ff;
      out_in       = out_ff;
      out_v_in     = (out_v_ff && rsp.ready) ? 1'b0 : out_v_ff;
      flow_we      = 1'b0;
      flow_addr    = i_ff[FLOW_AW-1:0];
      flow_wdata   = '0;
      allow_we     = 1'b0;
      allow_addr   = i_ff[ALLOW_AW-1:0];
      allow_wdata  = key_ff;
      block_we     = 1'b0;
      block_addr   = i_ff[BLOCK_AW-1:0];
      block_wdata  = key_ff;

      case (state_ff)
         ST_IDLE: begin
            i_in      = '0;
            key_in    = req.table_address;
            status_in = STATUS_NOTFOUND;
            case (req.command)
               CMD_PACKET: begin
                  sel_in  = LIST_FLOW;
                  cont_in = ST_FLOW_UPD;
                  key_in  = plain_ok ? req.source_plain : req.source_shifted;
                  port_in = plain_ok ? req.port_plain : req.port_shifted;
               end
               CMD_ALLOW: begin
                  sel_in  = LIST_ALLOW;
                  cont_in = ST_ADD_A;
               end
               CMD_DISALOW: begin
                  sel_in  = LIST_ALLOW;
                  cont_in = ST_DEL_A;
               end
               CMD_UNBLOCK: begin
                  sel_in  = LIST_BLOCK;
                  cont_in = ST_UNB_A;
               end
               default: begin
                  sel_in = sel_ff;
               end
            endcase
         end
         ST_SCAN_RD: begin
            if (i_ff == len) begin
               found_in = 1'b0;
            end
         end
         ST_SCAN_CMP: begin
            if (match) begin
               found_in = 1'b1;
               idx_in   = i_ff;
               cnt_in   = flow_rdata[COUNT_W-1:0];
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_FLOW_UPD: begin
            if (found_ff) begin
               flow_we    = 1'b1;
               flow_addr  = idx_ff[FLOW_AW-1:0];
               flow_wdata = {key_ff, port_ff, (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1};
            end else if (32'(flows_ff) < FLOW_ENTRIES) begin
               flow_we    = 1'b1;
               flow_addr  = flows_ff[FLOW_AW-1:0];
               flow_wdata = {key_ff, port_ff, COUNT_W'(1)};
               flows_in   = flows_ff + 1'b1;
            end
         end
         ST_WIN_START: begin
            limit_in = product[COUNT_W+7:8];
            fi_in    = '0;
         end
         ST_WIN_RD: begin
            flow_addr = fi_ff[FLOW_AW-1:0];
         end
         ST_WIN_CHK: begin
            fi_in   = fi_ff + 1'b1;
            key_in  = flow_rdata[FLOW_DW-1:FLOW_DW-32];
            sel_in  = LIST_ALLOW;
            i_in    = '0;
            cont_in = ST_WIN_ALW;
         end
         ST_WIN_ALW: begin
            sel_in  = LIST_BLOCK;
            i_in    = '0;
            cont_in = ST_WIN_BLK;
         end
         ST_WIN_BLK: begin
            if (!found_ff) begin
               block_we   = 1'b1;
               block_addr = blocks_ff[BLOCK_AW-1:0];
               blocks_in  = blocks_ff + 1'b1;
            end
         end
         ST_WIN_PUSH: begin
            // A new block lets the held one go out as not the final result.
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_in   = '{KIND_BLOCKED, STATUS_OK, pend_addr_ff, 1'b0};
                  out_v_in = 1'b1;
               end
               pend_v_in    = 1'b1;
               pend_addr_in = key_ff;
            end
         end
         ST_WIN_END: begin
            flows_in = '0;
            if (out_free) begin
               if (pend_v_ff) begin
                  out_in = '{KIND_BLOCKED, STATUS_OK, pend_addr_ff, 1'b1};
               end else begin
                  out_in = '{KIND_WINDOW, STATUS_OK, 32'd0, 1'b1};
               end
               out_v_in  = 1'b1;
               pend_v_in = 1'b0;
            end
         end
         ST_ADD_A: begin
            if (found_ff) begin
               status_in = STATUS_OK;
            end else if (32'(allows_ff) >= ALLOW_ENTRIES) begin
               status_in = STATUS_FULL;
            end else begin
               status_in  = STATUS_OK;
               allow_we   = 1'b1;
               allow_addr = allows_ff[ALLOW_AW-1:0];
               allows_in  = allows_ff + 1'b1;
               sel_in     = LIST_BLOCK;
               i_in       = '0;
               cont_in    = ST_ADD_B;
            end
         end
         ST_ADD_B, ST_DEL_A, ST_UNB_A: begin
            if (found_ff) begin
               status_in = STATUS_OK;
               i_in      = idx_ff + 1'b1;
               cont_in   = ST_RESP;
            end
         end
         ST_RM_RD: begin
            if (i_ff == len) begin
               if (sel_ff == LIST_ALLOW) begin
                  allows_in = allows_ff - 1'b1;
               end else begin
                  blocks_in = blocks_ff - 1'b1;
               end
            end
         end
         ST_RM_WR: begin
            // Close the gap: entry i moves down to i - 1.
            allow_addr  = ALLOW_AW'(i_ff - 1'b1);
            block_addr  = BLOCK_AW'(i_ff - 1'b1);
            allow_wdata = list_rdata;
            block_wdata = list_rdata;
            allow_we    = (sel_ff == LIST_ALLOW);
            block_we    = (sel_ff == LIST_BLOCK);
            i_in        = i_ff + 1'b1;
         end
         ST_RESP: begin
            if (out_free) begin
               out_in   = '{KIND_STATUS, status_ff, 32'd0, 1'b1};
               out_v_in = 1'b1;
            end
         end
         default: begin
            out_in = out_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         flows_ff  <= '0;
         blocks_ff <= '0;
         allows_ff <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         flows_ff  <= flows_in;
         blocks_ff <= blocks_in;
         allows_ff <= allows_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      cont_ff      <= cont_in;
      sel_ff       <= sel_in;
      i_ff         <= i_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      key_ff       <= key_in;
      port_ff      <= port_in;
      cnt_ff       <= cnt_in;
      limit_ff     <= limit_in;
      status_ff    <= status_in;
      fi_ff        <= fi_in;
      pend_addr_ff <= pend_addr_in;
      out_ff       <= out_in;
   end

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = out_v_ff;
   assign rsp.kind            = out_ff.kind;
   assign rsp.status          = out_ff.status;
   assign rsp.blocked_address = out_ff.blocked_address;
   assign rsp.last            = out_ff.last;

   `UFB_ASSERT_IMPL(a_flows_bound, clock, reset, 1'b1, 32'(flows_ff) <= FLOW_ENTRIES)
   `UFB_ASSERT_IMPL(a_allows_bound, clock, reset, 1'b1, 32'(allows_ff) <= ALLOW_ENTRIES)
   `UFB_ASSERT_IMPL(a_blocks_bound, clock, reset, 1'b1, 32'(blocks_ff) <= BLOCK_ENTRIES)
   `UFB_ASSERT_IMPL(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_v_ff)
   `UFB_ASSERT_NEXT(a_win_clears, clock, reset, state_ff == ST_WIN_END && out_free,
                    flows_ff == '0)
endmodule

>>> design/udp_flood_flow_blocker.sv
// ----------------------------------------------------------------------------
// udp_flood_flow_blocker
// Per-flow UDP packet-rate flood detector with allow and block lists.
// ----------------------------------------------------------------------------
// One item is taken at a time; the block is not ready while it works. A packet
// searches the 64-entry flow table entry by entry, then bumps the count of the
// flow it finds or, while there is room, adds a new flow. A window reads every
// flow and, for each qualifying flow, scans the allow list and, when the flow
// is not allowed, the block list; table commands search their list and, on
// removal, move the later entries down by one place. The searches are paced by
// the single-port list memories, read once per compare by the one shared
// compare unit. No clearing pass is run after reset: the lists are tracked by
// fill counts.
module udp_flood_flow_blocker import ufb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   ufb_req_if.sink     req,
   ufb_rsp_if.source   rsp
);
   cfg_type             cfg_ff;
   logic                flow_we, allow_we, block_we;
   logic [FLOW_AW-1:0]  flow_addr;
   logic [ALLOW_AW-1:0] allow_addr;
   logic [BLOCK_AW-1:0] block_addr;
   logic [FLOW_DW-1:0]  flow_wdata, flow_rdata;
   logic [31:0]         allow_wdata, allow_rdata, block_wdata, block_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{DEF_RATE, DEF_Q8, DEF_LIMIT};
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RATE:  cfg_ff.rate  <= csr_write_data;
            CSR_Q8:    cfg_ff.q8    <= csr_write_data;
            CSR_LIMIT: cfg_ff.limit <= csr_write_data[11:0];
            default:   cfg_ff       <= cfg_ff;
         endcase
      end
   end

   ufb_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req         (req),
      .rsp         (rsp),
      .flow_we     (flow_we),
      .flow_addr   (flow_addr),
      .flow_wdata  (flow_wdata),
      .flow_rdata  (flow_rdata),
      .allow_we    (allow_we),
      .allow_addr  (allow_addr),
      .allow_wdata (allow_wdata),
      .allow_rdata (allow_rdata),
      .block_we    (block_we),
      .block_addr  (block_addr),
      .block_wdata (block_wdata),
      .block_rdata (block_rdata)
   );

   ufb_ram #(.WIDTH(FLOW_DW), .DEPTH(FLOW_ENTRIES)) u_flow_ram (
      .clock (clock),
      .we    (flow_we),
      .addr  (flow_addr),
      .wdata (flow_wdata),
      .rdata (flow_rdata)
   );

   ufb_ram #(.WIDTH(32), .DEPTH(ALLOW_ENTRIES)) u_allow_ram (
      .clock (clock),
      .we    (allow_we),
      .addr  (allow_addr),
      .wdata (allow_wdata),
      .rdata (allow_rdata)
   );

   ufb_ram #(.WIDTH(32), .DEPTH(BLOCK_ENTRIES)) u_block_ram (
      .clock (clock),
      .we    (block_we),
      .addr  (block_addr),
      .wdata (block_wdata),
      .rdata (block_rdata)
   );
endmodule
